// ----- sv/ssi_pkg.sv -----
// Shared types and codes for the sorted set insert unit.
package ssi_pkg;

	localparam int ValW  = 32;
	localparam int StatW = 2;
	localparam int PosW  = 6;

	localparam logic [StatW-1:0] STAT_INSERTED  = 2'd0;
	localparam logic [StatW-1:0] STAT_DUPLICATE = 2'd1;
	localparam logic [StatW-1:0] STAT_FULL      = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} ssi_state_t;

	// Token handed from one cell to the next.
	typedef struct packed {
		logic            vld;    // token present
		logic            carry;  // data is a displaced entry moving up
		logic            probe;  // store full: search only, never write
		logic [ValW-1:0] data;
	} ssi_tok_t;

	// Per-cell events reported to the controller.
	typedef struct packed {
		logic dup;   // equal entry found
		logic ins;   // new value written here
		logic fin;   // last value parked in a free cell
		logic full;  // search ended with no match in a full store
	} ssi_evt_t;

endpackage

// ----- sv/ssi_cell.sv -----
// One storage cell of the sorted chain: compare, keep or swap, hand on.
module ssi_cell #(
	parameter int IDX = 0,
	parameter int CW  = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CW-1:0]    fill,
	input  ssi_pkg::ssi_tok_t tok_in,
	output ssi_pkg::ssi_tok_t tok_out,
	output ssi_pkg::ssi_evt_t evt
);
	import ssi_pkg::*;

	logic [ValW-1:0] held_q;
	ssi_tok_t        tok_q;
	ssi_tok_t        tok_nxt;
	logic            wr;
	logic            occupied;

	assign occupied = (CW'(IDX) < fill);

	always_comb begin
		tok_nxt = '0;
		evt     = '0;
		wr      = 1'b0;
		if (tok_in.vld) begin
			if (tok_in.carry) begin
				// displaced entry: take it, pass ours on
				wr = 1'b1;
				if (occupied) begin
					tok_nxt = '{vld: 1'b1, carry: 1'b1, probe: 1'b0, data: held_q};
				end else begin
					evt.fin = 1'b1;
				end
			end else if (occupied && held_q == tok_in.data) begin
				evt.dup = 1'b1;
			end else if (occupied && $signed(held_q) < $signed(tok_in.data)) begin
				tok_nxt = tok_in;
			end else if (tok_in.probe) begin
				evt.full = 1'b1;
			end else begin
				evt.ins = 1'b1;
				wr      = 1'b1;
				if (occupied) begin
					tok_nxt = '{vld: 1'b1, carry: 1'b1, probe: 1'b0, data: held_q};
				end else begin
					evt.fin = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			held_q <= tok_in.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;

endmodule

// ----- sv/ssi_ctrl.sv -----
// Request intake, fill count and result register for the sorted chain.
module ssi_ctrl #(
	parameter int DEPTH = 64,
	parameter int CW    = 7,
	parameter int IW    = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [ssi_pkg::ValW-1:0]     value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ssi_pkg::StatW-1:0]    status,
	output logic [ssi_pkg::PosW-1:0]     position,
	input  ssi_pkg::ssi_evt_t            evt,
	output ssi_pkg::ssi_tok_t            inj,
	output logic [CW-1:0]                fill
);
	import ssi_pkg::*;

	ssi_state_t       state_q, state_nxt;
	ssi_tok_t         inj_q;
	logic [CW-1:0]    count_q;
	logic [IW-1:0]    step_q;
	logic [IW-1:0]    pos_q;
	logic             out_valid_q;
	logic [StatW-1:0] status_q;
	logic [PosW-1:0]  position_q;
	logic             accept;
	logic             done;
	logic [StatW-1:0] res_stat;
	logic [IW-1:0]    res_pos;
	logic [IW+PosW-1:0] res_pos_ext;

	assign accept = in_valid && in_ready;
	assign done   = (state_q == ST_RUN) && (evt.dup || evt.full || evt.fin);
	assign res_pos_ext = {{PosW{1'b0}}, res_pos};

	always_comb begin
		state_nxt = state_q;
		in_ready  = 1'b0;
		res_stat  = STAT_INSERTED;
		res_pos   = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = !out_valid_q || out_ready;
				if (in_valid && in_ready) begin
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: begin
				if (evt.dup) begin
					res_stat = STAT_DUPLICATE;
				end else if (evt.full) begin
					res_stat = STAT_FULL;
				end else begin
					res_pos = evt.ins ? step_q : pos_q;
				end
				if (done) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			inj_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			inj_q   <= '0;
			if (accept) begin
				inj_q <= '{vld: 1'b1, carry: 1'b0,
					probe: (count_q == CW'(DEPTH)), data: value};
			end
			if (done && evt.fin) begin
				count_q <= count_q + CW'(1);
			end
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			step_q <= '0;
		end else begin
			step_q <= step_q + IW'(1);
		end
		if (evt.ins) begin
			pos_q <= step_q;
		end
		if (done) begin
			status_q   <= res_stat;
			position_q <= res_pos_ext[PosW-1:0];
		end
	end

	assign inj       = inj_q;
	assign fill      = count_q;
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign position  = position_q;

endmodule

// ----- sv/sorted_set_insert_unit.sv -----
// Top level of the sorted set insert unit: controller plus a chain of storage cells.
// An insert at index p finishes when the displaced tail reaches the first free cell;
// a duplicate or a reject at index p finishes at cell p, a full-store reject at the
// latest when the probe leaves the last cell. The token walks one cell per cycle.
// Throughput: one request at a time; the next request is taken once the result
// register is free or being drained. Reset empties the set (fill count cleared).
module sorted_set_insert_unit #(
	parameter int DEPTH = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [ssi_pkg::ValW-1:0] value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [ssi_pkg::StatW-1:0] status,
	output logic [ssi_pkg::PosW-1:0]  position
);
	import ssi_pkg::*;

	// Fill count must hold DEPTH itself; step index covers cell numbers only.
	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	ssi_tok_t      tok [DEPTH+1];
	ssi_evt_t      cell_evt [DEPTH];
	ssi_evt_t      evt_any;
	logic [CW-1:0] fill;

	// Intake and result handling. A request enters cell 0 through the
	// injection register the cycle after it is accepted.
	ssi_ctrl #(
		.DEPTH (DEPTH),
		.CW    (CW),
		.IW    (IW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.position  (position),
		.evt       (evt_any),
		.inj       (tok[0]),
		.fill      (fill)
	);

	// The chain: cells below the fill count hold the set in ascending order.
	// A search token passes cells holding smaller values, stops on an equal
	// one, and at the first larger or free cell drops its value in (a probe
	// in a full store stops there); displaced entries then ripple up one cell per cycle.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		ssi_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.fill    (fill),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1]),
			.evt     (cell_evt[i])
		);
	end

	// Only one token is ever in flight, so at most one cell reports at a
	// time; merge the reports. A probe that leaves the last cell found no
	// match in a full store.
	always_comb begin
		evt_any = '0;
		for (int j = 0; j < DEPTH; j++) begin
			evt_any.dup  = evt_any.dup  | cell_evt[j].dup;
			evt_any.ins  = evt_any.ins  | cell_evt[j].ins;
			evt_any.fin  = evt_any.fin  | cell_evt[j].fin;
			evt_any.full = evt_any.full | cell_evt[j].full;
		end
		evt_any.full = evt_any.full | tok[DEPTH].vld;
	end

endmodule

// ----- bench/sorted_set_insert_unit_test.sv -----
// Self-checking bench for the sorted set insert unit: directed, then random requests against a queue-based model.
module sorted_set_insert_unit_test;

	import ssi_pkg::*;

	localparam int SET_DEPTH     = 64;
	localparam int DIRECT_COUNT  = 16;
	localparam int RANDOM_COUNT  = 1934;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int IDLE_PERCENT  = 19;
	localparam int HOLD_AFTER    = 400;   // results seen before the long receiver hold
	localparam int HOLD_CYCLES   = 500;
	localparam int STEADY_FIRST  = 800;   // random requests offered with no idling at all
	localparam int STEADY_LAST   = 1100;
	localparam int DRAIN_AT      = 1200;  // random request index where the sender waits for all results
	localparam int PRINT_CAP     = 40;

	localparam logic signed [ValW-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [ValW-1:0] VAL_MAX = 32'sh7fff_ffff;

	// Expected outcome of one request.
	typedef struct packed {
		logic [StatW-1:0] status;
		logic [PosW-1:0]  position;
	} set_outcome_t;

	// Tracks the ascending set the unit should hold and the results still owed.
	class sorted_set_tracker;
		logic signed [ValW-1:0] members[$];
		set_outcome_t           owed[$];
		int                     mismatches;

		function new();
			mismatches = 0;
		endfunction

		function int outstanding();
			return owed.size();
		endfunction

		task report(input string what);
			if (mismatches < PRINT_CAP)
				$display("mismatch at %0t: %s", $time, what);
			mismatches++;
		endtask

		// Search for the first member not below v; a match is a duplicate, even when full.
		function void note_request(input logic signed [ValW-1:0] v);
			int           idx;
			bit           dup;
			set_outcome_t res;
			idx = 0;
			dup = 1'b0;
			while (idx < members.size()) begin
				if (members[idx] == v) begin
					dup = 1'b1;
					break;
				end
				if (members[idx] > v)
					break;
				idx++;
			end
			res.position = '0;
			if (dup) begin
				res.status = STAT_DUPLICATE;
			end else if (members.size() >= SET_DEPTH) begin
				res.status = STAT_FULL;
			end else begin
				res.status   = STAT_INSERTED;
				res.position = idx[PosW-1:0];
				members.insert(idx, v);
			end
			owed.push_back(res);
		endfunction

		task check_result(input logic [StatW-1:0] st, input logic [PosW-1:0] pos);
			set_outcome_t want;
			if (owed.size() == 0) begin
				report($sformatf("result with nothing pending: status %0d position %0d",
					st, pos));
			end else begin
				want = owed.pop_front();
				if (st !== want.status)
					report($sformatf("status %0d, expected %0d", st, want.status));
				if (pos !== want.position)
					report($sformatf("position %0d, expected %0d", pos, want.position));
			end
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic signed [ValW-1:0] value;
	logic                   out_valid;
	logic                   out_ready;
	logic [StatW-1:0]       status;
	logic [PosW-1:0]        position;

	sorted_set_tracker tracker = new();
	int                results_seen = 0;
	bit                steady = 1'b0;   // set by the sender: no idling on either side

	sorted_set_insert_unit #(
		.DEPTH(SET_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.position(position)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Offer one request; hold valid and payload until the unit takes it.
	// Idle first at random, with gaps long enough to land on any step of the cell walk.
	task automatic offer_value(input logic signed [ValW-1:0] v);
		int gap;
		if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
			gap = $urandom_range(70, 1);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		do @(posedge clk); while (!in_ready);
		tracker.note_request(v);
	endtask

	// Drop valid and wait until every owed result has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (tracker.outstanding() != 0);
	endtask

	// Pick a request value. While the set fills, favor duplicates so the inserts spread
	// over a few hundred requests; once full, mix duplicates at every index with rejects.
	function automatic logic signed [ValW-1:0] choose_value();
		int                     roll;
		int                     n;
		logic signed [ValW-1:0] pick;
		logic signed [ValW-1:0] edge_val;
		n    = tracker.members.size();
		roll = $urandom_range(99);
		pick = (n != 0) ? tracker.members[$urandom_range(n - 1)] : '0;
		case ($urandom_range(3))
			0: edge_val = VAL_MIN;
			1: edge_val = VAL_MAX;
			2: edge_val = '0;
			default: edge_val = -1;
		endcase
		if (n == 0)
			return $urandom();
		if (n < SET_DEPTH) begin
			if (roll < 12)
				return $urandom();
			if (roll < 20)
				return roll[0] ? pick + 1 : pick - 1;
			if (roll < 23)
				return edge_val;
			return pick;
		end
		if (roll < 30)
			return $urandom();
		if (roll < 40)
			return roll[0] ? pick + 1 : pick - 1;
		if (roll < 50)
			return edge_val;
		return pick;
	endfunction

	// Stimulus: reset, directed requests, then the random run.
	initial begin
		logic signed [ValW-1:0] directed[DIRECT_COUNT];
		arst_n    = 1'b0;
		in_valid  <= 1'b0;
		value     <= '0;
		directed = '{
			32'sd0, VAL_MIN, VAL_MAX, -32'sd1, 32'sd1,
			32'sd0,                 // duplicate in the middle
			VAL_MIN,                // duplicate at index zero
			VAL_MAX,                // duplicate at the last index
			32'sd5, 32'sd3, 32'sd4, // inserts between existing members
			VAL_MIN + 1, VAL_MAX - 1,
			32'sh5555_5555, 32'shaaaa_aaaa,
			32'sd1
		};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			offer_value(directed[i]);
		wait_drained();

		for (int i = 0; i < RANDOM_COUNT; i++) begin
			steady = (i >= STEADY_FIRST && i < STEADY_LAST);
			if (i == DRAIN_AT)
				wait_drained();
			offer_value(choose_value());
		end
		steady = 1'b0;

		// Let the last walk finish and catch any stray result.
		wait_drained();
		repeat (SET_DEPTH + 8) @(posedge clk);
		if (tracker.outstanding() != 0)
			tracker.report($sformatf("%0d results never came", tracker.outstanding()));
		if (tracker.mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Receiver: stall at random, never in the steady stretch, and once hold off for a
	// long while so the result register backs up and the unit stops taking requests.
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (steady) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	// Compare every accepted result with the oldest owed outcome.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			tracker.check_result(status, position);
			results_seen++;
		end
	end

	// Stop a hung run.
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Simulation FAILED");
		$finish;
	end

endmodule
